/* rtl/core/obp_pkg.sv */
// Shared types and constants for the online bin packer.
package obp_pkg;

	localparam int unsigned MAX_BINS_DEF = 256;
	localparam int unsigned WEIGHT_W     = 16;
	localparam int unsigned INDEX_OUT_W  = 8;
	localparam int unsigned COUNT_OUT_W  = 9;
	localparam int unsigned APB_AW       = 3;
	localparam int unsigned APB_DW       = 32;

	localparam logic [WEIGHT_W-1:0] CAP_RESET = 16'd10;

	typedef enum logic [1:0] {
		FIT_NEXT  = 2'd0,
		FIT_FIRST = 2'd1,
		FIT_BEST  = 2'd2,
		FIT_WORST = 2'd3
	} fit_mode_t;

	localparam fit_mode_t MODE_RESET = FIT_FIRST;

	// register index, taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_MODE     = 1'b1;

	typedef struct packed {
		logic [WEIGHT_W-1:0] capacity;
		fit_mode_t           mode;
	} cfg_t;

	typedef struct packed {
		logic                   set_done;
		logic                   table_full;
		logic                   oversize;
		logic                   new_bin;
		logic [COUNT_OUT_W-1:0] bins_used;
		logic [INDEX_OUT_W-1:0] bin_index;
	} result_t;

endpackage

/* rtl/core/online_bin_packer_top.sv */
// Top level of the online bin packer: APB registers, streams and result register.
//
// Each input beat carries one item weight and is placed into an open bin by the
// selected policy (next, first, best or worst fit), or a new bin is opened.
// Bin remaining capacities live in a single-port-read RAM of MAX_BINS entries;
// the engine reads one bin per cycle while scanning, so an item that scans N
// bins holds the engine through N reads, a drain state and a commit state that
// waits for the output register (N is one for next fit and all open bins for
// the other policies). An oversize item or an item that meets an empty table
// skips the scan and goes straight to commit. A finished result sits in the
// output register, so the next item is accepted while it waits. A beat with
// tlast set clears the bin table after its result. Configure only while idle.
module online_bin_packer_top #(
	parameter int unsigned MAX_BINS = obp_pkg::MAX_BINS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [obp_pkg::APB_AW-1:0]  paddr,
	input  logic [obp_pkg::APB_DW-1:0]  pwdata,
	output logic [obp_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [15:0]                 s_axis_tdata,  // item_weight
	input  logic                        s_axis_tlast,  // last_item
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [23:0]                 m_axis_tdata,  // bin_index, bins_used, zero pad
	output logic [2:0]                  m_axis_tuser,  // new_bin, oversize, table_full
	output logic                        m_axis_tlast   // set_done
);

	import obp_pkg::*;

	logic [WEIGHT_W-1:0] cap_q;
	fit_mode_t           mode_q;
	cfg_t                cfg;
	logic                cfg_wr;
	logic                res_valid;
	logic                res_ready;
	result_t             res;
	logic                out_valid_q;
	result_t             out_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			mode_q <= MODE_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_CAPACITY: cap_q  <= pwdata[WEIGHT_W-1:0];
				REG_MODE:     mode_q <= fit_mode_t'(pwdata[1:0]);
				default:      cap_q  <= cap_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_CAPACITY: prdata = APB_DW'(cap_q);
			REG_MODE:     prdata = APB_DW'(mode_q);
			default:      prdata = '0;
		endcase
	end

	assign cfg.capacity = cap_q;
	assign cfg.mode     = mode_q;

	obp_engine #(
		.MAX_BINS (MAX_BINS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_weight (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
			out_q       <= res;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_q.bins_used, out_q.bin_index};
	assign m_axis_tuser  = {out_q.table_full, out_q.oversize, out_q.new_bin};
	assign m_axis_tlast  = out_q.set_done;

`ifndef ASSERT_OFF
	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("engine accepted a beat while busy");

	a_oversize_unplaced: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |->
			m_axis_tdata[7:0] == 8'd0 && !m_axis_tuser[0] && !m_axis_tuser[2])
		else $error("oversize item reported as placed");

	a_full_unplaced: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |->
			m_axis_tdata[7:0] == 8'd0 && !m_axis_tuser[0] && !m_axis_tuser[1])
		else $error("table full result inconsistent");
`endif

endmodule

/* rtl/core/obp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module obp_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/obp_engine.sv */
// Placement engine: scans bin remaining capacities in RAM and writes back the chosen bin.
module obp_engine #(
	parameter int unsigned MAX_BINS = obp_pkg::MAX_BINS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  obp_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [obp_pkg::WEIGHT_W-1:0]  in_weight,
	input  logic                          in_last,
	output logic                          res_valid,
	input  logic                          res_ready,
	output obp_pkg::result_t              res
);

	import obp_pkg::*;

	localparam int unsigned IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_BINS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    open_q;
	logic [IDX_W-1:0]    j_q;
	logic [IDX_W-1:0]    j_s1;
	logic                v_s1;
	logic [WEIGHT_W-1:0] w_q;
	logic                last_q;
	logic                over_q;
	logic                found_q;
	logic [IDX_W-1:0]    idx_q;
	logic [WEIGHT_W-1:0] left_q;

	logic [IDX_W-1:0]    last_idx;
	logic [WEIGHT_W-1:0] rd_data;
	logic                fits;
	logic [WEIGHT_W-1:0] left;
	logic                take;
	logic                has_room;
	logic                is_new;
	logic                is_full;
	logic [CNT_W-1:0]    open_next;
	logic [IDX_W-1:0]    idx_out;
	logic                commit_go;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [WEIGHT_W-1:0] wr_data;

	assign last_idx = IDX_W'(open_q - CNT_W'(1));
	assign fits     = rd_data >= w_q;
	assign left     = rd_data - w_q;

	always_comb begin
		case (cfg.mode)
			FIT_NEXT, FIT_FIRST: take = fits && !found_q;
			FIT_BEST:            take = fits && (!found_q || (left < left_q));
			FIT_WORST:           take = fits && (!found_q || (left > left_q));
			default:             take = 1'b0;
		endcase
	end

	assign has_room  = open_q < CNT_W'(MAX_BINS);
	assign is_new    = !over_q && !found_q && has_room;
	assign is_full   = !over_q && !found_q && !has_room;
	assign open_next = is_new ? open_q + CNT_W'(1) : open_q;
	assign idx_out   = found_q ? idx_q : (is_new ? IDX_W'(open_q) : '0);

	assign res_valid = (state_q == ST_COMMIT);
	assign commit_go = res_valid && res_ready;
	assign in_ready  = (state_q == ST_IDLE);

	assign res.bin_index  = INDEX_OUT_W'(idx_out);
	assign res.bins_used  = COUNT_OUT_W'(open_next);
	assign res.new_bin    = is_new;
	assign res.oversize   = over_q;
	assign res.table_full = is_full;
	assign res.set_done   = last_q;

	// write-back happens in the commit cycle, before the next item can issue a read
	assign wr_en   = commit_go && (found_q || is_new);
	assign wr_addr = found_q ? idx_q : IDX_W'(open_q);
	assign wr_data = found_q ? left_q : cfg.capacity - w_q;

	obp_ram #(
		.WIDTH (WEIGHT_W),
		.DEPTH (MAX_BINS),
		.AW    (IDX_W)
	) u_bin_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (state_q == ST_SCAN),
		.raddr (j_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			open_q  <= '0;
			v_s1    <= 1'b0;
			last_q  <= 1'b0;
			over_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SCAN);
			j_s1 <= j_q;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						w_q     <= in_weight;
						last_q  <= in_last;
						over_q  <= in_weight > cfg.capacity;
						found_q <= 1'b0;
						idx_q   <= '0;
						j_q     <= (cfg.mode == FIT_NEXT) ? last_idx : '0;
						if ((in_weight > cfg.capacity) || (open_q == '0)) begin
							state_q <= ST_COMMIT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					j_q <= j_q + IDX_W'(1);
					if (j_q == last_idx) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (res_ready) begin
						open_q  <= last_q ? '0 : open_next;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (v_s1 && take) begin
				found_q <= 1'b1;
				idx_q   <= j_s1;
				left_q  <= left;
			end
		end
	end

endmodule
